@@ hdl/rlsf_pkg.sv @@
`timescale 1ns / 1ps
package rlsf_pkg;

  localparam int MAX_HEIGHT_DEF = 512;
  localparam int MAX_WIDTH_DEF  = 4096;

  localparam int DATA_W     = 16;
  localparam int HEIGHT_W   = 10;
  localparam int WIDTH_W    = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b1;

  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 10'd3;
  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 13'd3;

  localparam int FRAC_W = 14;
  localparam int ACC_W  = 35;
  localparam int Q_W    = ACC_W - FRAC_W;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef logic signed [DATA_W-1:0]   sample_t;
  typedef logic signed [2*DATA_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic signed [Q_W-1:0]      q_t;

  localparam acc_t    ROUND_HALF = acc_t'(8192);
  localparam q_t      Q_MAX      = q_t'(32767);
  localparam q_t      Q_MIN      = q_t'(-32768);
  localparam sample_t SAT_MAX    = 16'sh7fff;
  localparam sample_t SAT_MIN    = 16'sh8000;

  typedef struct packed {
    sample_t sample;
    sample_t weight_self;
    sample_t weight_right;
    sample_t weight_up_right;
    sample_t weight_down_right;
    sample_t weight_below;
  } item_t;

  typedef struct packed {
    logic has_right;
    logic up_ok;
    logic dn_ok;
    logic below_ok;
    logic image_end;
  } pos_flags_t;

  typedef struct packed {
    sample_t filtered;
    logic    image_end;
  } result_t;

  // round half up to Q8.8, then saturate
  function automatic sample_t round_sat(acc_t acc);
    acc_t    v;
    q_t      q;
    sample_t y;
    v = acc + ROUND_HALF;
    q = v[ACC_W-1:FRAC_W];
    if (q > Q_MAX) begin
      y = SAT_MAX;
    end else if (q < Q_MIN) begin
      y = SAT_MIN;
    end else begin
      y = q[DATA_W-1:0];
    end
    return y;
  endfunction

endpackage

@@ hdl/rlsf_in_if.sv @@
`timescale 1ns / 1ps
interface rlsf_in_if;
  import rlsf_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;
  sample_t weight_self;
  sample_t weight_right;
  sample_t weight_up_right;
  sample_t weight_down_right;
  sample_t weight_below;

  modport source (
    output valid, sample, weight_self, weight_right, weight_up_right,
           weight_down_right, weight_below,
    input  ready
  );

  modport sink (
    input  valid, sample, weight_self, weight_right, weight_up_right,
           weight_down_right, weight_below,
    output ready
  );
endinterface

@@ hdl/rlsf_out_if.sv @@
`timescale 1ns / 1ps
interface rlsf_out_if;
  import rlsf_pkg::*;

  logic    valid;
  logic    ready;
  sample_t filtered;
  logic    image_end;

  modport source (
    output valid, filtered, image_end,
    input  ready
  );

  modport sink (
    input  valid, filtered, image_end,
    output ready
  );
endinterface

@@ hdl/recursive_left_scan_filter.sv @@
`timescale 1ns / 1ps
// channel   dir  payload                                        handshake
// in_ch     in   sample, weights self/right/up/down/below       valid/ready
// out_ch    out  filtered, image_end                            valid/ready
// cfg_*     in   cfg_index, cfg_data                            cfg_we
//
// One pixel per cycle for image heights of 4 rows and up, while the result queue
// has room. For heights 1 to 3 a pixel waits while the column store entry it reads
// is still in the multiply pipeline (stages B, C).
// A taken request passes stages B, C and D; stage D pushes its result into the queue.
// Synchronous active-low reset clears the pipeline, queue and counters; size is 3x3.
// Results queue in 8 entries; in_ch.ready drops when queued and in-flight results fill them.
module recursive_left_scan_filter #(
  parameter int MAX_HEIGHT = rlsf_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_WIDTH  = rlsf_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  rlsf_in_if.sink                         in_ch,
  rlsf_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [rlsf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rlsf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rlsf_pkg::*;

  localparam int RW = $clog2(MAX_HEIGHT > 1 ? MAX_HEIGHT : 2);

  logic [RW-1:0]      row;
  pos_flags_t         pos_flags;
  item_t              item;
  logic               take;
  logic               hazard;
  logic [1:0]         in_flight;
  logic               res_vld;
  result_t            res;
  logic [FIFO_CW-1:0] fifo_cnt;
  logic               room;

  assign item.sample            = in_ch.sample;
  assign item.weight_self       = in_ch.weight_self;
  assign item.weight_right      = in_ch.weight_right;
  assign item.weight_up_right   = in_ch.weight_up_right;
  assign item.weight_down_right = in_ch.weight_down_right;
  assign item.weight_below      = in_ch.weight_below;

  assign room        = (FIFO_CW'(in_flight) + fifo_cnt) < FIFO_CW'(FIFO_DEPTH);
  assign in_ch.ready = room && !hazard;
  assign take        = in_ch.valid && in_ch.ready;

  rlsf_seq #(
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .row       (row),
    .pos_flags (pos_flags)
  );

  rlsf_filt #(
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_filt (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .row_in    (row),
    .flags_in  (pos_flags),
    .item_in   (item),
    .hazard    (hazard),
    .in_flight (in_flight),
    .res_vld   (res_vld),
    .res       (res)
  );

  rlsf_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_vld),
    .push_data (res),
    .out_ch    (out_ch),
    .count     (fifo_cnt)
  );

endmodule

@@ hdl/rlsf_seq.sv @@
`timescale 1ns / 1ps
module rlsf_seq #(
  parameter int MAX_HEIGHT = rlsf_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_WIDTH  = rlsf_pkg::MAX_WIDTH_DEF,
  localparam int RW = $clog2(MAX_HEIGHT > 1 ? MAX_HEIGHT : 2)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [rlsf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rlsf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             take,
  output logic [RW-1:0]                    row,
  output rlsf_pkg::pos_flags_t             pos_flags
);
  import rlsf_pkg::*;

  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int CW = $clog2(MAX_WIDTH > 1 ? MAX_WIDTH : 2);
  localparam int WW = $clog2(MAX_WIDTH + 1);

  logic [HEIGHT_W-1:0] cfg_h_r;
  logic [WIDTH_W-1:0]  cfg_w_r;
  logic [HW-1:0]       h_eff;
  logic [WW-1:0]       w_eff;
  logic [RW-1:0]       row_cnt_r;
  logic [CW-1:0]       col_cnt_r;
  logic [RW-1:0]       r;
  logic [CW-1:0]       c;
  logic                last_row;
  logic                last_col;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_h_r <= HEIGHT_RST;
      cfg_w_r <= WIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEIGHT: cfg_h_r <= cfg_data[HEIGHT_W-1:0];
        CFG_WIDTH:  cfg_w_r <= cfg_data[WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_h_r == '0) begin
      h_eff = HW'(1);
    end else if (32'(cfg_h_r) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(cfg_h_r);
    end
    if (cfg_w_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(cfg_w_r) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_w_r);
    end
  end

  // counters left beyond a shrunk size restart at zero
  assign r        = (HW'(row_cnt_r) >= h_eff) ? '0 : row_cnt_r;
  assign c        = (WW'(col_cnt_r) >= w_eff) ? '0 : col_cnt_r;
  assign last_row = (HW'(r) == h_eff - HW'(1));
  assign last_col = (WW'(c) == w_eff - WW'(1));

  assign row                 = r;
  assign pos_flags.has_right = (c != '0);
  assign pos_flags.up_ok     = (c != '0) && !last_row;
  assign pos_flags.dn_ok     = (c != '0) && (r != '0);
  assign pos_flags.below_ok  = (r != '0);
  assign pos_flags.image_end = last_row && last_col;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= '0;
      col_cnt_r <= '0;
    end else if (take) begin
      if (last_row) begin
        row_cnt_r <= '0;
        col_cnt_r <= last_col ? '0 : c + CW'(1);
      end else begin
        row_cnt_r <= r + RW'(1);
        col_cnt_r <= c;
      end
    end
  end

endmodule

@@ hdl/rlsf_filt.sv @@
`timescale 1ns / 1ps
module rlsf_filt #(
  parameter int MAX_HEIGHT = rlsf_pkg::MAX_HEIGHT_DEF,
  localparam int RW = $clog2(MAX_HEIGHT > 1 ? MAX_HEIGHT : 2)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 take,
  input  logic [RW-1:0]        row_in,
  input  rlsf_pkg::pos_flags_t flags_in,
  input  rlsf_pkg::item_t      item_in,
  output logic                 hazard,
  output logic [1:0]           in_flight,
  output logic                 res_vld,
  output rlsf_pkg::result_t    res
);
  import rlsf_pkg::*;

  sample_t    mem [MAX_HEIGHT];
  logic [RW-1:0] up_addr;

  // stage B: store read data available
  logic       vb_r;
  logic [RW-1:0] row_b_r;
  pos_flags_t flg_b_r;
  item_t      item_b_r;
  sample_t    rd_right_r;
  sample_t    rd_up_r;
  sample_t    held_r;
  logic [RW-1:0] up_b;
  sample_t    right_raw;
  sample_t    up_raw;
  sample_t    right_v;
  sample_t    upr_v;
  sample_t    dnr_v;
  prod_t      p_self;
  prod_t      p_right;
  prod_t      p_up;
  prod_t      p_dn;

  // stage C: partial sum
  logic       vc_r;
  logic [RW-1:0] row_c_r;
  prod_t      p_self_c_r;
  prod_t      p_right_c_r;
  prod_t      p_up_c_r;
  prod_t      p_dn_c_r;
  sample_t    s_c_r;
  sample_t    wb_c_r;
  logic       below_ok_c_r;
  logic       end_c_r;
  acc_t       partial;

  // stage D: recursive term, round, write back
  logic       vd_r;
  logic [RW-1:0] row_d_r;
  acc_t       part_d_r;
  sample_t    s_d_r;
  sample_t    wb_d_r;
  logic       below_ok_d_r;
  logic       end_d_r;
  sample_t    below_v;
  prod_t      p_below;
  sample_t    y_nxt;

  // last written value, doubles as the pixel below
  sample_t    y_r;
  logic       y_vld_r;
  logic [RW-1:0] y_row_r;

  assign up_addr = row_in + RW'(1);

  always_ff @(posedge clk) begin
    if (take) begin
      rd_right_r <= mem[row_in];
      rd_up_r    <= mem[up_addr];
    end
    if (vd_r) begin
      mem[row_d_r] <= y_nxt;
    end
  end

  // interlock: the entry is still in B or C, not yet written or forwardable
  assign hazard =
    (flags_in.has_right &&
     ((vb_r && row_b_r == row_in) || (vc_r && row_c_r == row_in))) ||
    (flags_in.up_ok &&
     ((vb_r && row_b_r == up_addr) || (vc_r && row_c_r == up_addr)));

  assign in_flight = {1'b0, vb_r} + {1'b0, vc_r} + {1'b0, vd_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      vb_r <= take;
      vc_r <= vb_r;
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      row_b_r  <= row_in;
      flg_b_r  <= flags_in;
      item_b_r <= item_in;
    end
  end

  assign up_b      = row_b_r + RW'(1);
  assign right_raw = (y_vld_r && y_row_r == row_b_r) ? y_r : rd_right_r;
  assign up_raw    = (y_vld_r && y_row_r == up_b) ? y_r : rd_up_r;
  assign right_v   = flg_b_r.has_right ? right_raw : item_b_r.sample;
  assign upr_v     = flg_b_r.up_ok ? up_raw : item_b_r.sample;
  assign dnr_v     = flg_b_r.dn_ok ? held_r : item_b_r.sample;

  assign p_self  = item_b_r.sample * item_b_r.weight_self;
  assign p_right = right_v * item_b_r.weight_right;
  assign p_up    = upr_v * item_b_r.weight_up_right;
  assign p_dn    = dnr_v * item_b_r.weight_down_right;

  // old entry of the previous pixel's row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (vb_r) begin
      held_r <= right_raw;
    end
  end

  always_ff @(posedge clk) begin
    row_c_r      <= row_b_r;
    p_self_c_r   <= p_self;
    p_right_c_r  <= p_right;
    p_up_c_r     <= p_up;
    p_dn_c_r     <= p_dn;
    s_c_r        <= item_b_r.sample;
    wb_c_r       <= item_b_r.weight_below;
    below_ok_c_r <= flg_b_r.below_ok;
    end_c_r      <= flg_b_r.image_end;
  end

  assign partial = acc_t'(p_self_c_r) + acc_t'(p_right_c_r) +
                   acc_t'(p_up_c_r) + acc_t'(p_dn_c_r);

  always_ff @(posedge clk) begin
    row_d_r      <= row_c_r;
    part_d_r     <= partial;
    s_d_r        <= s_c_r;
    wb_d_r       <= wb_c_r;
    below_ok_d_r <= below_ok_c_r;
    end_d_r      <= end_c_r;
  end

  assign below_v = below_ok_d_r ? y_r : s_d_r;
  assign p_below = below_v * wb_d_r;
  assign y_nxt   = round_sat(part_d_r + acc_t'(p_below));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_r     <= '0;
      y_vld_r <= 1'b0;
    end else if (vd_r) begin
      y_r     <= y_nxt;
      y_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (vd_r) begin
      y_row_r <= row_d_r;
    end
  end

  assign res_vld       = vd_r;
  assign res.filtered  = y_nxt;
  assign res.image_end = end_d_r;

  a_right_vs_c: assert property (@(posedge clk) disable iff (!rst_n)
    vb_r && flg_b_r.has_right && vc_r |-> row_c_r != row_b_r)
    else $error("right entry read while older write in stage C");

  a_right_vs_d: assert property (@(posedge clk) disable iff (!rst_n)
    vb_r && flg_b_r.has_right && vd_r |-> row_d_r != row_b_r)
    else $error("right entry read while older write in stage D");

  a_up_vs_c: assert property (@(posedge clk) disable iff (!rst_n)
    vb_r && flg_b_r.up_ok && vc_r |-> row_c_r != up_b)
    else $error("up-right entry read while older write in stage C");

  a_up_vs_d: assert property (@(posedge clk) disable iff (!rst_n)
    vb_r && flg_b_r.up_ok && vd_r |-> row_d_r != up_b)
    else $error("up-right entry read while older write in stage D");

endmodule

@@ hdl/rlsf_fifo.sv @@
`timescale 1ns / 1ps
module rlsf_fifo (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  rlsf_pkg::result_t              push_data,
  rlsf_out_if.source                     out_ch,
  output logic [rlsf_pkg::FIFO_CW-1:0]   count
);
  import rlsf_pkg::*;

  result_t              q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r;
  logic [FIFO_AW-1:0]   rd_ptr_r;
  logic [FIFO_CW-1:0]   cnt_r;
  logic                 pop;

  assign pop              = out_ch.valid && out_ch.ready;
  assign out_ch.valid     = (cnt_r != '0);
  assign out_ch.filtered  = q[rd_ptr_r].filtered;
  assign out_ch.image_end = q[rd_ptr_r].image_end;
  assign count            = cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      cnt_r <= cnt_r + FIFO_CW'(push) - FIFO_CW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> cnt_r != FIFO_CW'(FIFO_DEPTH))
    else $error("result queue overflow");

endmodule
